// ===== src/bgbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgbc_pkg
// shared types, command codes and element depth helpers for the bit-granular
// block copy core
// ----------------------------------------------------------------------------
package bgbc_pkg;

  // default memory size in bytes
  localparam int MEM_BYTES_DEF = 256;

  // element count scaled to bits: up to 4095 * 32
  localparam int SCALED_W = 17;

  // highest bit index inside a byte
  localparam logic [2:0] BIT_IDX_MAX = 3'h7;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_BLIT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // element depth codes
  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_4  = 3'd1;
  localparam logic [2:0] DEPTH_8  = 3'd2;
  localparam logic [2:0] DEPTH_16 = 3'd3;
  localparam logic [2:0] DEPTH_24 = 3'd4;
  localparam logic [2:0] DEPTH_32 = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_RD_WAIT,
    ST_RD_SRC,
    ST_LD_SRC,
    ST_RD_DST,
    ST_LD_DST,
    ST_SHIFT,
    ST_WRITE,
    ST_DONE
  } state_t;

  // element count or position times the element depth, by shift and add
  function automatic logic [SCALED_W-1:0] elem_to_bits(logic [11:0] n, logic [2:0] code);
    logic [SCALED_W-1:0] v;
    v = SCALED_W'(n);
    case (code)
      DEPTH_1:  return v;
      DEPTH_4:  return v << 2;
      DEPTH_8:  return v << 3;
      DEPTH_16: return v << 4;
      DEPTH_24: return (v << 4) + (v << 3);
      DEPTH_32: return v << 5;
      default:  return '0;
    endcase
  endfunction

  function automatic logic depth_valid(logic [2:0] code);
    case (code)
      DEPTH_1, DEPTH_4, DEPTH_8, DEPTH_16, DEPTH_24, DEPTH_32: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

// ===== src/bgbc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgbc_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module bgbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/bit_granular_block_copy_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_granular_block_copy_core
// byte memory with byte write, byte read and bit-granular blit commands
// ----------------------------------------------------------------------------
// usage:
//   one command word enters on the in_ channel (valid/ready), one result word
//   leaves on the out_ channel (valid/ready) for every command.
//   a byte write passes ST_DECODE, where memory is written, and ST_DONE; a
//   byte read passes ST_DECODE, ST_RD_WAIT and ST_DONE. a blit copies one bit
//   per cycle while both byte registers are loaded, through a source byte
//   register and a destination byte register; each source byte is fetched in
//   ST_RD_SRC and ST_LD_SRC, each destination byte in ST_RD_DST and ST_LD_DST
//   and written back in ST_WRITE; the single memory read port serialises them.
//   the copy walks upward, or downward when the destination starts above the
//   source, so overlapping regions get the source as it stood before.
//   a blit that falls off the end of memory, or has an undefined depth,
//   returns status 1 and writes nothing.
//   in_ready is high only in idle, in the cycle after the result is loaded, so a
//   new command is accepted only once the previous one has finished.
//   a finished result sits in the output register, so the next command may be
//   accepted while the receiver stalls; a command finishing behind a stalled
//   result waits. reset clears the control state; memory is undefined until
//   written.
// ----------------------------------------------------------------------------
module bit_granular_block_copy_core
  import bgbc_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_byte_addr,
  input  logic [7:0]  in_write_data,
  input  logic [10:0] in_src_pos,
  input  logic [10:0] in_dst_pos,
  input  logic [11:0] in_count,
  input  logic [2:0]  in_depth_code,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_status
);

  // byte address, bit position and check widths
  localparam int AW = $clog2(MEM_BYTES);
  localparam int PW = AW + 3;
  localparam int CW = (AW + 4 > SCALED_W + 1) ? AW + 4 : SCALED_W + 1;
  localparam logic [CW-1:0] TOTAL_BITS = CW'(MEM_BYTES * 8);

  state_t state_r, state_nxt;

  // latched command word
  logic [1:0]  cmd_r;
  logic [7:0]  addr_r;
  logic [7:0]  wdata_r;
  logic [10:0] src_r;
  logic [10:0] dst_r;
  logic [11:0] cnt_r;
  logic [2:0]  code_r;

  // blit extents in bits
  logic [SCALED_W-1:0] s0_r, s0_nxt;
  logic [SCALED_W-1:0] d0_r, d0_nxt;
  logic [SCALED_W-1:0] len_r, len_nxt;
  logic                dok_r, dok_nxt;

  // bit-serial copy datapath
  logic [PW-1:0] sbit_r, sbit_nxt;
  logic [PW-1:0] dbit_r, dbit_nxt;
  logic [PW:0]   rem_r, rem_nxt;
  logic [AW-1:0] dadr_r, dadr_nxt;
  logic [7:0]    sbyte_r, sbyte_nxt;
  logic [7:0]    dbyte_r, dbyte_nxt;
  logic          need_src_r, need_src_nxt;
  logic          need_dst_r, need_dst_nxt;
  logic          rev_r, rev_nxt;
  logic          s_edge;
  logic          d_edge;

  // result waiting for the output register
  logic [7:0] res_data_r, res_data_nxt;
  logic       res_status_r, res_status_nxt;

  // output register
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_status_r;
  logic       out_load;

  // memory port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic in_fire;
  logic addr_ok;
  logic over;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign addr_ok  = (32'(addr_r) < MEM_BYTES);

  // region checks against the memory size
  assign over = ((CW'(s0_r) + CW'(len_r)) > TOTAL_BITS) ||
                ((CW'(d0_r) + CW'(len_r)) > TOTAL_BITS);

  // last bit of a byte in the walking direction
  assign s_edge = rev_r ? (sbit_r[2:0] == '0) : (sbit_r[2:0] == BIT_IDX_MAX);
  assign d_edge = rev_r ? (dbit_r[2:0] == '0) : (dbit_r[2:0] == BIT_IDX_MAX);

  bgbc_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // command word capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_cmd;
      addr_r  <= in_byte_addr;
      wdata_r <= in_write_data;
      src_r   <= in_src_pos;
      dst_r   <= in_dst_pos;
      cnt_r   <= in_count;
      code_r  <= in_depth_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      need_src_r <= 1'b0;
      need_dst_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      need_src_r <= need_src_nxt;
      need_dst_r <= need_dst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r         <= s0_nxt;
    d0_r         <= d0_nxt;
    len_r        <= len_nxt;
    dok_r        <= dok_nxt;
    sbit_r       <= sbit_nxt;
    dbit_r       <= dbit_nxt;
    rem_r        <= rem_nxt;
    dadr_r       <= dadr_nxt;
    sbyte_r      <= sbyte_nxt;
    dbyte_r      <= dbyte_nxt;
    rev_r        <= rev_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    s0_nxt         = s0_r;
    d0_nxt         = d0_r;
    len_nxt        = len_r;
    dok_nxt        = dok_r;
    sbit_nxt       = sbit_r;
    dbit_nxt       = dbit_r;
    rem_nxt        = rem_r;
    dadr_nxt       = dadr_r;
    sbyte_nxt      = sbyte_r;
    dbyte_nxt      = dbyte_r;
    rev_nxt        = rev_r;
    need_src_nxt   = need_src_r;
    need_dst_nxt   = need_dst_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = dadr_r;
    ram_wdata      = dbyte_r;
    ram_re         = 1'b0;
    ram_raddr      = sbit_r[PW-1:3];
    out_load       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_data_nxt   = '0;
        res_status_nxt = 1'b0;
        case (cmd_t'(cmd_r))
          CMD_WRITE: begin
            // write straight through, or flag an address past the end
            if (addr_ok) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(addr_r);
              ram_wdata = wdata_r;
            end else begin
              res_status_nxt = 1'b1;
            end
            state_nxt = ST_DONE;
          end
          CMD_READ: begin
            if (addr_ok) begin
              ram_re    = 1'b1;
              ram_raddr = AW'(addr_r);
              state_nxt = ST_RD_WAIT;
            end else begin
              res_status_nxt = 1'b1;
              state_nxt      = ST_DONE;
            end
          end
          CMD_BLIT: begin
            // element positions and count turned into bit positions
            s0_nxt    = elem_to_bits({1'b0, src_r}, code_r);
            d0_nxt    = elem_to_bits({1'b0, dst_r}, code_r);
            len_nxt   = elem_to_bits(cnt_r, code_r);
            dok_nxt   = depth_valid(code_r);
            state_nxt = ST_CHECK;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_CHECK: begin
        if (!dok_r || over) begin
          res_status_nxt = 1'b1;
          state_nxt      = ST_DONE;
        end else if (len_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          // destination above source walks down from the last bit
          rev_nxt = (d0_r > s0_r);
          if (d0_r > s0_r) begin
            sbit_nxt = PW'(CW'(s0_r) + CW'(len_r) - CW'(1));
            dbit_nxt = PW'(CW'(d0_r) + CW'(len_r) - CW'(1));
          end else begin
            sbit_nxt = PW'(s0_r);
            dbit_nxt = PW'(d0_r);
          end
          // both byte registers start empty
          rem_nxt      = (PW + 1)'(len_r);
          need_src_nxt = 1'b1;
          need_dst_nxt = 1'b1;
          state_nxt    = ST_RD_SRC;
        end
      end

      ST_RD_WAIT: begin
        res_data_nxt = ram_rdata;
        state_nxt    = ST_DONE;
      end

      ST_RD_SRC: begin
        ram_re    = 1'b1;
        ram_raddr = sbit_r[PW-1:3];
        state_nxt = ST_LD_SRC;
      end

      ST_LD_SRC: begin
        sbyte_nxt    = ram_rdata;
        need_src_nxt = 1'b0;
        state_nxt    = need_dst_r ? ST_RD_DST : ST_SHIFT;
      end

      ST_RD_DST: begin
        ram_re    = 1'b1;
        ram_raddr = dbit_r[PW-1:3];
        state_nxt = ST_LD_DST;
      end

      ST_LD_DST: begin
        dbyte_nxt    = ram_rdata;
        dadr_nxt     = dbit_r[PW-1:3];
        need_dst_nxt = 1'b0;
        state_nxt    = ST_SHIFT;
      end

      ST_SHIFT: begin
        // move one bit from the source byte into the destination byte
        dbyte_nxt[dbit_r[2:0]] = sbyte_r[sbit_r[2:0]];
        sbit_nxt     = rev_r ? sbit_r - PW'(1) : sbit_r + PW'(1);
        dbit_nxt     = rev_r ? dbit_r - PW'(1) : dbit_r + PW'(1);
        rem_nxt      = rem_r - (PW + 1)'(1);
        need_src_nxt = s_edge;
        need_dst_nxt = d_edge;
        if (rem_r == (PW + 1)'(1) || d_edge) begin
          state_nxt = ST_WRITE;
        end else if (s_edge) begin
          state_nxt = ST_RD_SRC;
        end else begin
          state_nxt = ST_SHIFT;
        end
      end

      ST_WRITE: begin
        // bits of the byte outside the run come back unchanged
        ram_we    = 1'b1;
        ram_waddr = dadr_r;
        ram_wdata = dbyte_r;
        if (rem_r == '0) begin
          state_nxt = ST_DONE;
        end else if (need_src_r) begin
          state_nxt = ST_RD_SRC;
        end else begin
          state_nxt = ST_RD_DST;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register, decoupled from the command side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r   <= res_data_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_status    = out_status_r;

endmodule
